// ===== sv/tti_pkg.sv =====
// shared types, constants and command/status structs for the trilinear table interpolator
`default_nettype none
package tti_pkg;

  localparam int VW = 32;
  localparam int TAB_AW = 11;
  localparam int PTS_AW = 6;
  localparam int IDX_W = 4;

  localparam logic [4:0] MAX_XC = 5'd16;
  localparam logic [4:0] MAX_YC = 5'd16;
  localparam logic [3:0] MAX_DC = 4'd8;

  // breakpoint memory layout: x, y and depth vectors share one memory
  localparam logic [PTS_AW-1:0] X_BASE = 6'd0;
  localparam logic [PTS_AW-1:0] Y_BASE = 6'd16;
  localparam logic [PTS_AW-1:0] D_BASE = 6'd32;

  localparam logic [1:0] CFG_X_COUNT = 2'd0;
  localparam logic [1:0] CFG_Y_COUNT = 2'd1;
  localparam logic [1:0] CFG_D_COUNT = 2'd2;
  localparam logic [1:0] CFG_ROW_MAJOR = 2'd3;

  typedef enum logic [2:0] {
    REQ_WR_TABLE = 3'd0,
    REQ_WR_X     = 3'd1,
    REQ_WR_Y     = 3'd2,
    REQ_WR_D     = 3'd3,
    REQ_FWD      = 3'd4,
    REQ_INV_X    = 3'd5,
    REQ_INV_Y    = 3'd6,
    REQ_INV_D    = 3'd7
  } req_t;

  // which vector a bracket search walks
  typedef enum logic [1:0] {
    VEC_X = 2'd0,
    VEC_Y = 2'd1,
    VEC_D = 2'd2,
    VEC_R = 2'd3
  } vec_t;

  typedef enum logic [2:0] {
    BR_NONE      = 3'd0,
    BR_INIT      = 3'd1,
    BR_LAST      = 3'd2,
    BR_NEXT      = 3'd3,
    BR_HIT_FIRST = 3'd4,
    BR_HIT_LAST  = 3'd5,
    BR_HIT_SCAN  = 3'd6
  } br_op_t;

  typedef enum logic [1:0] {
    LD_NONE      = 2'd0,
    LD_ISSUE     = 2'd1,
    LD_CAP_START = 2'd2,
    LD_CAP_END   = 2'd3
  } ld_t;

  // interpolation steps of one trilinear pass, plus the final inverse step
  localparam logic [2:0] LS_F1_DS = 3'd0;
  localparam logic [2:0] LS_F2_DS = 3'd1;
  localparam logic [2:0] LS_A     = 3'd2;
  localparam logic [2:0] LS_F1_DE = 3'd3;
  localparam logic [2:0] LS_F2_DE = 3'd4;
  localparam logic [2:0] LS_B     = 3'd5;
  localparam logic [2:0] LS_DEPTH = 3'd6;
  localparam logic [2:0] LS_FINAL = 3'd7;

  typedef struct packed {
    logic       idle;
    br_op_t     br_op;
    vec_t       vec;
    ld_t        ld;
    logic [2:0] lsel;
    logic       lerp_start;
    logic       store;
    logic       k_clr;
    logic       k_inc;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic ge;
    logic le;
    logic lerp_done;
    logic k_last;
    logic fwd;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/tti_lerp.sv =====
// multi-cycle linear step: 32x32 multiply then restoring divide, saturated sum
`default_nettype none
module tti_lerp (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  xs,
  input  logic signed [31:0]  ys,
  input  logic signed [31:0]  xe,
  input  logic signed [31:0]  ye,
  input  logic signed [31:0]  xp,
  output logic                done,
  output logic signed [31:0]  res
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_DIV  = 4'b0100,
    L_FIN  = 4'b1000
  } lstate_t;

  lstate_t state;
  logic [31:0] am, bm, dm;
  logic neg;
  logic signed [31:0] ysr;
  logic [63:0] prod;
  logic [31:0] rem;
  logic [5:0] cnt;

  logic signed [32:0] dx, dy, dp;
  logic [32:0] trial, diff;
  logic fits;
  logic [34:0] qm;
  logic signed [35:0] qs, sum;
  logic signed [31:0] sat_sum;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  always_comb begin
    dx = {xe[31], xe} - {xs[31], xs};
    dy = {ye[31], ye} - {ys[31], ys};
    dp = {xp[31], xp} - {xs[31], xs};
    trial = {rem, prod[63]};
    fits = trial >= {1'b0, dm};
    diff = trial - {1'b0, dm};
    // anything at or above 2^34 saturates the same way after the add
    qm = (|prod[63:34]) ? {1'b1, 34'd0} : prod[34:0];
    qs = neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    sum = {{4{ysr[31]}}, ysr} + qs;
    if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111) begin
      sat_sum = sum[31:0];
    end else if (sum[35]) begin
      sat_sum = {1'b1, 31'd0};
    end else begin
      sat_sum = {1'b0, {31{1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            if (dx == 33'sd0) begin
              res <= ys;
              done <= 1'b1;
            end else begin
              state <= L_MUL;
            end
          end
        end
        L_MUL: begin
          state <= L_DIV;
        end
        L_DIV: begin
          if (cnt == 6'd63) begin
            state <= L_FIN;
          end
        end
        L_FIN: begin
          res <= sat_sum;
          done <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      L_IDLE: begin
        am <= mag33(dy);
        bm <= mag33(dp);
        dm <= mag33(dx);
        neg <= ((dy < 0) != (dp < 0)) != (dx < 0);
        ysr <= ys;
      end
      L_MUL: begin
        prod <= {32'd0, am} * {32'd0, bm};
        rem <= 32'd0;
        cnt <= 6'd0;
      end
      L_DIV: begin
        rem <= fits ? diff[31:0] : trial[31:0];
        prod <= {prod[62:0], fits};
        cnt <= cnt + 6'd1;
      end
      L_FIN: begin
        cnt <= 6'd0;
      end
      default: cnt <= 6'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/tti_datapath.sv =====
// datapath: config registers, table and breakpoint memories, bracket logic, operand loads
`default_nettype none
module tti_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tti_pkg::cmd_t       cmd,
  output tti_pkg::status_t    status,
  input  logic                in_accept,
  input  logic [2:0]          in_req,
  input  logic [10:0]         in_index,
  input  logic signed [31:0]  in_wvalue,
  input  logic signed [31:0]  in_qx,
  input  logic signed [31:0]  in_qy,
  input  logic signed [31:0]  in_qz,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [31:0]  out_value,
  output logic [1:0]          out_kind
);

  logic [4:0] x_count, y_count;
  logic [3:0] depth_count;
  logic row_major;
  logic [4:0] xc, yc, dc5, n_inv, nsel;
  logic [3:0] dc;

  tti_pkg::req_t req;
  logic signed [31:0] qx, qy, qz, q_ax, tsel;

  logic signed [31:0] tab_mem [2**tti_pkg::TAB_AW];
  logic signed [31:0] pts_mem [2**tti_pkg::PTS_AW];
  logic signed [31:0] scr_mem [2**tti_pkg::IDX_W];
  logic signed [31:0] tab_rd, pts_rd, scr_rd, br_rd;
  logic [tti_pkg::TAB_AW-1:0] tab_raddr;
  logic [tti_pkg::PTS_AW-1:0] pts_raddr, pts_waddr, ax_base, vbase;
  logic [tti_pkg::IDX_W-1:0] scr_raddr;
  logic pts_we, tab_we, scr_we;

  logic [3:0] bi, br_idx, hit_s, hit_e;
  logic [3:0] bxs, bxe, bys, bye, bds, bde, rs, re, k;
  logic [3:0] xs_e, xe_e, ys_e, ye_e, ds_e, de_e, yy;
  logic [2:0] lay;
  logic [tti_pkg::PTS_AW-1:0] a0, a1;
  logic [tti_pkg::TAB_AW-1:0] t0, t1;

  logic signed [31:0] op_xs, op_ys, op_xe, op_ye, op_xp;
  logic signed [31:0] f1, f2, va, vb, resv, lres;
  logic lerp_done;

  function automatic logic [7:0] plane_off(input logic [3:0] ix, input logic [3:0] iy,
                                           input logic [4:0] cx, input logic [4:0] cy,
                                           input logic rm);
    logic [8:0] t;
    t = rm ? ({5'd0, iy} * {4'd0, cx} + {5'd0, ix})
           : ({5'd0, ix} * {4'd0, cy} + {5'd0, iy});
    return t[7:0];
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      x_count <= tti_pkg::MAX_XC;
      y_count <= tti_pkg::MAX_YC;
      depth_count <= tti_pkg::MAX_DC;
      row_major <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tti_pkg::CFG_X_COUNT:   x_count <= cfg_data;
        tti_pkg::CFG_Y_COUNT:   y_count <= cfg_data;
        tti_pkg::CFG_D_COUNT:   depth_count <= cfg_data[3:0];
        tti_pkg::CFG_ROW_MAJOR: row_major <= cfg_data[0];
        default:                row_major <= row_major;
      endcase
    end
  end

  always_comb begin
    xc = (x_count == 5'd0) ? 5'd1 : (x_count > tti_pkg::MAX_XC) ? tti_pkg::MAX_XC : x_count;
    yc = (y_count == 5'd0) ? 5'd1 : (y_count > tti_pkg::MAX_YC) ? tti_pkg::MAX_YC : y_count;
    dc = (depth_count == 4'd0) ? 4'd1 :
         (depth_count > tti_pkg::MAX_DC) ? tti_pkg::MAX_DC : depth_count;
    dc5 = {1'b0, dc};
  end

  // query capture
  always_ff @(posedge clk) begin
    if (in_accept && in_req[2]) begin
      req <= tti_pkg::req_t'(in_req);
      qx <= in_qx;
      qy <= in_qy;
      qz <= in_qz;
    end
  end

  always_comb begin
    unique case (req)
      tti_pkg::REQ_INV_X: begin
        n_inv = xc;
        q_ax = qx;
        ax_base = tti_pkg::X_BASE;
      end
      tti_pkg::REQ_INV_Y: begin
        n_inv = yc;
        q_ax = qy;
        ax_base = tti_pkg::Y_BASE;
      end
      default: begin
        n_inv = dc5;
        q_ax = qz;
        ax_base = tti_pkg::D_BASE;
      end
    endcase
    unique case (cmd.vec)
      tti_pkg::VEC_X: begin
        nsel = xc;
        tsel = qx;
        vbase = tti_pkg::X_BASE;
      end
      tti_pkg::VEC_Y: begin
        nsel = yc;
        tsel = qy;
        vbase = tti_pkg::Y_BASE;
      end
      tti_pkg::VEC_D: begin
        nsel = dc5;
        tsel = qz;
        vbase = tti_pkg::D_BASE;
      end
      default: begin
        nsel = n_inv;
        tsel = q_ax;
        vbase = tti_pkg::X_BASE;
      end
    endcase
  end

  // bracket walk
  always_comb begin
    unique case (cmd.br_op)
      tti_pkg::BR_LAST: br_idx = nsel[3:0] - 4'd1;
      tti_pkg::BR_NEXT: br_idx = bi + 4'd1;
      default:          br_idx = 4'd0;
    endcase
    unique case (cmd.br_op)
      tti_pkg::BR_HIT_LAST: begin
        hit_s = nsel[3:0] - 4'd1;
        hit_e = nsel[3:0] - 4'd1;
      end
      tti_pkg::BR_HIT_SCAN: begin
        hit_s = bi - 4'd1;
        hit_e = bi;
      end
      default: begin
        hit_s = 4'd0;
        hit_e = 4'd0;
      end
    endcase
    br_rd = (cmd.vec == tti_pkg::VEC_R) ? scr_rd : pts_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.br_op == tti_pkg::BR_INIT) begin
      bi <= 4'd0;
    end else if (cmd.br_op == tti_pkg::BR_NEXT) begin
      bi <= bi + 4'd1;
    end
    if (cmd.br_op == tti_pkg::BR_HIT_FIRST || cmd.br_op == tti_pkg::BR_HIT_LAST ||
        cmd.br_op == tti_pkg::BR_HIT_SCAN) begin
      unique case (cmd.vec)
        tti_pkg::VEC_X: begin
          bxs <= hit_s;
          bxe <= hit_e;
        end
        tti_pkg::VEC_Y: begin
          bys <= hit_s;
          bye <= hit_e;
        end
        tti_pkg::VEC_D: begin
          bds <= hit_s;
          bde <= hit_e;
        end
        default: begin
          rs <= hit_s;
          re <= hit_e;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.k_clr) begin
      k <= 4'd0;
    end else if (cmd.k_inc) begin
      k <= k + 4'd1;
    end
  end

  // the inverted axis collapses to a single entry k, which flattens its steps
  always_comb begin
    xs_e = (req == tti_pkg::REQ_INV_X) ? k : bxs;
    xe_e = (req == tti_pkg::REQ_INV_X) ? k : bxe;
    ys_e = (req == tti_pkg::REQ_INV_Y) ? k : bys;
    ye_e = (req == tti_pkg::REQ_INV_Y) ? k : bye;
    ds_e = (req == tti_pkg::REQ_INV_D) ? k : bds;
    de_e = (req == tti_pkg::REQ_INV_D) ? k : bde;
    lay = (cmd.lsel <= tti_pkg::LS_A) ? ds_e[2:0] : de_e[2:0];
    yy = (cmd.lsel == tti_pkg::LS_F2_DS || cmd.lsel == tti_pkg::LS_F2_DE) ? ye_e : ys_e;
    t0 = {lay, plane_off(xs_e, yy, xc, yc, row_major)};
    t1 = {lay, plane_off(xe_e, yy, xc, yc, row_major)};
    unique case (cmd.lsel)
      tti_pkg::LS_A, tti_pkg::LS_B: begin
        a0 = tti_pkg::Y_BASE + {2'd0, ys_e};
        a1 = tti_pkg::Y_BASE + {2'd0, ye_e};
      end
      tti_pkg::LS_DEPTH: begin
        a0 = tti_pkg::D_BASE + {2'd0, ds_e};
        a1 = tti_pkg::D_BASE + {2'd0, de_e};
      end
      tti_pkg::LS_FINAL: begin
        a0 = ax_base + {2'd0, rs};
        a1 = ax_base + {2'd0, re};
      end
      default: begin
        a0 = tti_pkg::X_BASE + {2'd0, xs_e};
        a1 = tti_pkg::X_BASE + {2'd0, xe_e};
      end
    endcase
    unique case (cmd.ld)
      tti_pkg::LD_ISSUE: begin
        pts_raddr = a0;
        tab_raddr = t0;
        scr_raddr = rs;
      end
      tti_pkg::LD_CAP_START: begin
        pts_raddr = a1;
        tab_raddr = t1;
        scr_raddr = re;
      end
      default: begin
        pts_raddr = vbase + {2'd0, br_idx};
        tab_raddr = t0;
        scr_raddr = br_idx;
      end
    endcase
  end

  // memories
  always_comb begin
    tab_we = in_accept && (in_req == tti_pkg::REQ_WR_TABLE);
    pts_we = 1'b0;
    pts_waddr = tti_pkg::X_BASE + {2'd0, in_index[3:0]};
    if (in_accept && in_req == tti_pkg::REQ_WR_X && in_index < 11'd16) begin
      pts_we = 1'b1;
    end else if (in_accept && in_req == tti_pkg::REQ_WR_Y && in_index < 11'd16) begin
      pts_we = 1'b1;
      pts_waddr = tti_pkg::Y_BASE + {2'd0, in_index[3:0]};
    end else if (in_accept && in_req == tti_pkg::REQ_WR_D && in_index < 11'd8) begin
      pts_we = 1'b1;
      pts_waddr = tti_pkg::D_BASE + {2'd0, in_index[3:0]};
    end
    scr_we = cmd.store && (cmd.lsel == tti_pkg::LS_DEPTH) && (req != tti_pkg::REQ_FWD);
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[in_index] <= in_wvalue;
    end
    tab_rd <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (pts_we) begin
      pts_mem[pts_waddr] <= in_wvalue;
    end
    pts_rd <= pts_mem[pts_raddr];
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[k] <= lres;
    end
    scr_rd <= scr_mem[scr_raddr];
  end

  // operand loads
  always_ff @(posedge clk) begin
    if (cmd.ld == tti_pkg::LD_CAP_START) begin
      op_xs <= (cmd.lsel == tti_pkg::LS_FINAL) ? scr_rd : pts_rd;
      unique case (cmd.lsel)
        tti_pkg::LS_A, tti_pkg::LS_B: op_ys <= f1;
        tti_pkg::LS_DEPTH:            op_ys <= va;
        tti_pkg::LS_FINAL:            op_ys <= pts_rd;
        default:                      op_ys <= tab_rd;
      endcase
    end
    if (cmd.ld == tti_pkg::LD_CAP_END) begin
      op_xe <= (cmd.lsel == tti_pkg::LS_FINAL) ? scr_rd : pts_rd;
      unique case (cmd.lsel)
        tti_pkg::LS_A, tti_pkg::LS_B: begin
          op_ye <= f2;
          op_xp <= qy;
        end
        tti_pkg::LS_DEPTH: begin
          op_ye <= vb;
          op_xp <= qz;
        end
        tti_pkg::LS_FINAL: begin
          op_ye <= pts_rd;
          op_xp <= q_ax;
        end
        default: begin
          op_ye <= tab_rd;
          op_xp <= qx;
        end
      endcase
    end
  end

  tti_lerp u_lerp (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.lerp_start),
    .xs    (op_xs),
    .ys    (op_ys),
    .xe    (op_xe),
    .ye    (op_ye),
    .xp    (op_xp),
    .done  (lerp_done),
    .res   (lres)
  );

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      unique case (cmd.lsel)
        tti_pkg::LS_F1_DS, tti_pkg::LS_F1_DE: f1 <= lres;
        tti_pkg::LS_F2_DS, tti_pkg::LS_F2_DE: f2 <= lres;
        tti_pkg::LS_A:                        va <= lres;
        tti_pkg::LS_B:                        vb <= lres;
        default:                              resv <= lres;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value <= resv;
      out_kind <= req[1:0];
    end
  end

  always_comb begin
    status.ge = br_rd >= tsel;
    status.le = br_rd <= tsel;
    status.lerp_done = lerp_done;
    status.k_last = {1'b0, k} == (n_inv - 5'd1);
    status.fwd = req == tti_pkg::REQ_FWD;
    status.out_free = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ===== sv/tti_ctrl.sv =====
// controller: sequences brackets, operand loads, interpolation steps and output
`default_nettype none
module tti_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_accept,
  input  logic              in_query,
  input  tti_pkg::status_t  status,
  output tti_pkg::cmd_t     cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_BR0  = 11'b000_0000_0010,
    S_BR1  = 11'b000_0000_0100,
    S_BR2  = 11'b000_0000_1000,
    S_BR3  = 11'b000_0001_0000,
    S_LD0  = 11'b000_0010_0000,
    S_LD1  = 11'b000_0100_0000,
    S_LD2  = 11'b000_1000_0000,
    S_LGO  = 11'b001_0000_0000,
    S_LRUN = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;
  tti_pkg::vec_t vec, vec_next;
  logic [2:0] lsel, lsel_next;
  logic br_done;

  always_comb begin
    state_next = state;
    vec_next = vec;
    lsel_next = lsel;
    br_done = 1'b0;
    cmd = '0;
    cmd.vec = vec;
    cmd.lsel = lsel;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (in_accept && in_query) begin
          vec_next = tti_pkg::VEC_D;
          state_next = S_BR0;
        end
      end
      S_BR0: begin
        cmd.br_op = tti_pkg::BR_INIT;
        state_next = S_BR1;
      end
      S_BR1: begin
        if (status.ge) begin
          cmd.br_op = tti_pkg::BR_HIT_FIRST;
          br_done = 1'b1;
        end else begin
          cmd.br_op = tti_pkg::BR_LAST;
          state_next = S_BR2;
        end
      end
      S_BR2: begin
        if (status.le) begin
          cmd.br_op = tti_pkg::BR_HIT_LAST;
          br_done = 1'b1;
        end else begin
          cmd.br_op = tti_pkg::BR_NEXT;
          state_next = S_BR3;
        end
      end
      S_BR3: begin
        if (!status.le) begin
          cmd.br_op = tti_pkg::BR_HIT_SCAN;
          br_done = 1'b1;
        end else begin
          cmd.br_op = tti_pkg::BR_NEXT;
        end
      end
      S_LD0: begin
        cmd.ld = tti_pkg::LD_ISSUE;
        state_next = S_LD1;
      end
      S_LD1: begin
        cmd.ld = tti_pkg::LD_CAP_START;
        state_next = S_LD2;
      end
      S_LD2: begin
        cmd.ld = tti_pkg::LD_CAP_END;
        state_next = S_LGO;
      end
      S_LGO: begin
        cmd.lerp_start = 1'b1;
        state_next = S_LRUN;
      end
      S_LRUN: begin
        if (status.lerp_done) begin
          cmd.store = 1'b1;
          if (lsel == tti_pkg::LS_FINAL) begin
            state_next = S_OUT;
          end else if (lsel == tti_pkg::LS_DEPTH) begin
            if (status.fwd) begin
              state_next = S_OUT;
            end else if (status.k_last) begin
              vec_next = tti_pkg::VEC_R;
              state_next = S_BR0;
            end else begin
              cmd.k_inc = 1'b1;
              lsel_next = tti_pkg::LS_F1_DS;
              state_next = S_LD0;
            end
          end else begin
            lsel_next = lsel + 3'd1;
            state_next = S_LD0;
          end
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // bracket order: depth, x, y, then the trilinear passes; the value vector ends
    if (br_done) begin
      unique case (vec)
        tti_pkg::VEC_D: begin
          vec_next = tti_pkg::VEC_X;
          state_next = S_BR0;
        end
        tti_pkg::VEC_X: begin
          vec_next = tti_pkg::VEC_Y;
          state_next = S_BR0;
        end
        tti_pkg::VEC_Y: begin
          cmd.k_clr = 1'b1;
          lsel_next = tti_pkg::LS_F1_DS;
          state_next = S_LD0;
        end
        default: begin
          lsel_next = tti_pkg::LS_FINAL;
          state_next = S_LD0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vec <= tti_pkg::VEC_D;
      lsel <= tti_pkg::LS_F1_DS;
    end else begin
      state <= state_next;
      vec <= vec_next;
      lsel <= lsel_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/trilinear_table_interpolator.sv =====
// top level: trilinear lookup table interpolator with inverse lookups
//
//   channel   direction  handshake                 payload
//   s_axis    in         s_axis_tvalid/tready      tdata: index, value, x, y, z; tuser: kind
//   m_axis    out        m_axis_tvalid/tready      tdata: result value; tuser: result kind
//   cfg       in         cfg_we                    cfg_index, cfg_data
//
// a write transaction is taken while the controller stays idle. a query runs three bracket
// walks, depth, x and y, then interpolation steps on the shared multiply and divide unit
// (the divide is skipped where a breakpoint gap is zero): forward uses 7 steps, an inverse
// query 7 per entry of its axis plus one more walk and step. the result sits in an output
// register, so the next transaction is taken while it waits; a new result waits for it.
// reset is synchronous and restores the counts; table and breakpoints keep their contents.
`default_nettype none
module trilinear_table_interpolator (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [143:0]  s_axis_tdata,   // write_index, write_value, query_x, query_y, query_z
  input  logic [2:0]    s_axis_tuser,   // req_type
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [31:0]   m_axis_tdata,   // result_value
  output logic [1:0]    m_axis_tuser,   // result_kind
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [4:0]    cfg_data
);

  tti_pkg::cmd_t cmd;
  tti_pkg::status_t status;
  logic in_accept;
  logic signed [31:0] out_value;

  assign s_axis_tready = cmd.idle;
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata = out_value;

  tti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_query  (s_axis_tuser[2]),
    .status    (status),
    .cmd       (cmd)
  );

  tti_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_accept (in_accept),
    .in_req    (s_axis_tuser),
    .in_index  (s_axis_tdata[10:0]),
    .in_wvalue (s_axis_tdata[42:11]),
    .in_qx     (s_axis_tdata[74:43]),
    .in_qy     (s_axis_tdata[106:75]),
    .in_qz     (s_axis_tdata[138:107]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_value (out_value),
    .out_kind  (m_axis_tuser)
  );

endmodule
`default_nettype wire

// ===== sim/tb_trilinear_table_interpolator.sv =====
// testbench for trilinear_table_interpolator: random streams checked against a built-in predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_trilinear_table_interpolator;

  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  kind;
  } interp_result_t;

  class table_predictor;
    longint table_mem[2048];
    longint x_pts[16];
    longint y_pts[16];
    longint d_pts[8];
    logic [4:0] xcnt_reg, ycnt_reg;
    logic [3:0] dcnt_reg;
    logic       row_major_reg;
    interp_result_t expected_results[$];
    int errors;
    int results_seen;
    int query_count[4];
    int write_count;

    function new();
      xcnt_reg = tti_pkg::MAX_XC;
      ycnt_reg = tti_pkg::MAX_YC;
      dcnt_reg = tti_pkg::MAX_DC;
      row_major_reg = 1'b1;
      errors = 0;
      results_seen = 0;
      write_count = 0;
      foreach (query_count[i]) query_count[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [4:0] data);
      case (idx)
        tti_pkg::CFG_X_COUNT:   xcnt_reg = data;
        tti_pkg::CFG_Y_COUNT:   ycnt_reg = data;
        tti_pkg::CFG_D_COUNT:   dcnt_reg = data[3:0];
        tti_pkg::CFG_ROW_MAJOR: row_major_reg = data[0];
        default: ;
      endcase
    endfunction

    function int clamp_count(int c, int hi);
      if (c < 1) return 1;
      if (c > hi) return hi;
      return c;
    endfunction

    function longint sat32(longint v);
      if (v > SAT_MAX) return SAT_MAX;
      if (v < SAT_MIN) return SAT_MIN;
      return v;
    endfunction

    // exact product, division toward zero, magnitude capped at 2^62
    function longint lerp_q(longint xs, longint ys, longint xe, longint ye, longint xp);
      longint dx, dy, dp, qs;
      logic [63:0] a, b, d;
      logic [127:0] prod, quo;
      logic neg;
      dx = xe - xs;
      dy = ye - ys;
      dp = xp - xs;
      if (dx == 0) return sat32(ys);
      a = (dy < 0) ? -dy : dy;
      b = (dp < 0) ? -dp : dp;
      d = (dx < 0) ? -dx : dx;
      neg = ((dy < 0) != (dp < 0)) != (dx < 0);
      prod = {64'd0, a} * {64'd0, b};
      quo = prod / {64'd0, d};
      if (quo > 128'h4000_0000_0000_0000) quo = 128'h4000_0000_0000_0000;
      qs = longint'(quo[63:0]);
      if (neg) qs = -qs;
      return sat32(ys + qs);
    endfunction

    function void bracket(const ref longint v[], input int n, input longint t,
                          output int s, output int e);
      s = n - 1;
      e = n - 1;
      if (v[0] >= t) begin
        s = 0;
        e = 0;
      end else if (v[n-1] > t) begin
        for (int i = 1; i < n; i++) begin
          if (v[i] > t) begin
            s = i - 1;
            e = i;
            break;
          end
        end
      end
    endfunction

    function longint cell_val(int layer, int xi, int yi);
      int xc, yc, off;
      xc = clamp_count(xcnt_reg, 16);
      yc = clamp_count(ycnt_reg, 16);
      off = row_major_reg ? yi * xc + xi : xi * yc + yi;
      return table_mem[layer * 256 + off];
    endfunction

    function longint plane_val(int l, int xs, int xe, int ys, int ye, longint qx, longint qy);
      longint f1, f2;
      f1 = lerp_q(x_pts[xs], cell_val(l, xs, ys), x_pts[xe], cell_val(l, xe, ys), qx);
      f2 = lerp_q(x_pts[xs], cell_val(l, xs, ye), x_pts[xe], cell_val(l, xe, ye), qx);
      return lerp_q(y_pts[ys], f1, y_pts[ye], f2, qy);
    endfunction

    function void note_input(tti_pkg::req_t rq, logic [10:0] widx, logic [31:0] wv,
                             logic [31:0] qxr, logic [31:0] qyr, logic [31:0] qzr);
      longint xv[], yv[], dv[], rv[];
      longint qx, qy, qz, a, b, res;
      int xc, yc, dc, ds, de, xs, xe, ys, ye, s, e;
      interp_result_t item;
      qx = longint'($signed(qxr));
      qy = longint'($signed(qyr));
      qz = longint'($signed(qzr));
      xc = clamp_count(xcnt_reg, 16);
      yc = clamp_count(ycnt_reg, 16);
      dc = clamp_count(dcnt_reg, 8);
      case (rq)
        tti_pkg::REQ_WR_TABLE: table_mem[widx] = longint'($signed(wv));
        tti_pkg::REQ_WR_X: if (widx < 16) x_pts[widx] = longint'($signed(wv));
        tti_pkg::REQ_WR_Y: if (widx < 16) y_pts[widx] = longint'($signed(wv));
        tti_pkg::REQ_WR_D: if (widx < 8) d_pts[widx] = longint'($signed(wv));
        default: ;
      endcase
      if (rq inside {tti_pkg::REQ_WR_TABLE, tti_pkg::REQ_WR_X, tti_pkg::REQ_WR_Y,
                     tti_pkg::REQ_WR_D}) begin
        write_count++;
        return;
      end
      xv = x_pts;
      yv = y_pts;
      dv = d_pts;
      bracket(dv, dc, qz, ds, de);
      bracket(xv, xc, qx, xs, xe);
      bracket(yv, yc, qy, ys, ye);
      rv = new[16];
      case (rq)
        tti_pkg::REQ_FWD: begin
          a = plane_val(ds, xs, xe, ys, ye, qx, qy);
          b = plane_val(de, xs, xe, ys, ye, qx, qy);
          res = lerp_q(d_pts[ds], a, d_pts[de], b, qz);
        end
        tti_pkg::REQ_INV_X: begin
          for (int k = 0; k < xc; k++) begin
            a = lerp_q(y_pts[ys], cell_val(ds, k, ys), y_pts[ye], cell_val(ds, k, ye), qy);
            b = lerp_q(y_pts[ys], cell_val(de, k, ys), y_pts[ye], cell_val(de, k, ye), qy);
            rv[k] = lerp_q(d_pts[ds], a, d_pts[de], b, qz);
          end
          bracket(rv, xc, qx, s, e);
          res = lerp_q(rv[s], x_pts[s], rv[e], x_pts[e], qx);
        end
        tti_pkg::REQ_INV_Y: begin
          for (int k = 0; k < yc; k++) begin
            a = lerp_q(x_pts[xs], cell_val(ds, xs, k), x_pts[xe], cell_val(ds, xe, k), qx);
            b = lerp_q(x_pts[xs], cell_val(de, xs, k), x_pts[xe], cell_val(de, xe, k), qx);
            rv[k] = lerp_q(d_pts[ds], a, d_pts[de], b, qz);
          end
          bracket(rv, yc, qy, s, e);
          res = lerp_q(rv[s], y_pts[s], rv[e], y_pts[e], qy);
        end
        default: begin
          for (int k = 0; k < dc; k++) rv[k] = plane_val(k, xs, xe, ys, ye, qx, qy);
          bracket(rv, dc, qz, s, e);
          res = lerp_q(rv[s], d_pts[s], rv[e], d_pts[e], qz);
        end
      endcase
      item.value = res[31:0];
      item.kind = 2'(rq - tti_pkg::REQ_FWD);
      query_count[item.kind]++;
      expected_results.push_back(item);
    endfunction

    function void check_result(logic [31:0] value, logic [1:0] kind);
      interp_result_t exp_item;
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: result_value=%h result_kind=%0d", value, kind);
        errors++;
        return;
      end
      exp_item = expected_results.pop_front();
      if (value !== exp_item.value) begin
        $error("result_value: expected %h actual %h", exp_item.value, value);
        errors++;
      end
      if (kind !== exp_item.kind) begin
        $error("result_kind: expected %0d actual %0d", exp_item.kind, kind);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [143:0] s_axis_tdata;  // write_index, write_value, query_x, query_y, query_z
  logic [2:0] s_axis_tuser;    // req_type
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;   // result_value
  logic [1:0] m_axis_tuser;    // result_kind
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;

  table_predictor pred;
  int burst_left;
  int cyc = 0;
  int stall_mode = 0;
  // value ranges of the current breakpoints and table, for picking coordinates
  int x_lo, x_hi, y_lo, y_hi, d_lo, d_hi;
  int t_lo, t_hi;

  trilinear_table_interpolator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver stall pattern: always ready, random, mostly stalled, or alternating runs; the mode is redrawn at random
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 500 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= ((cyc / 37) % 2 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) pred.check_result(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_item(tti_pkg::req_t rq, logic [10:0] idx, logic [31:0] wv,
                           logic [31:0] qx, logic [31:0] qy, logic [31:0] qz);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= rq;
    s_axis_tdata <= {5'd0, qz, qy, qx, wv, idx};
    do @(posedge clk); while (!s_axis_tready);
    pred.note_input(rq, idx, wv, qx, qy, qz);
    burst_left--;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    pred.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pred.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_counts(logic [4:0] xc, logic [4:0] yc, logic [4:0] dc, logic rm);
    write_reg(tti_pkg::CFG_X_COUNT, xc);
    write_reg(tti_pkg::CFG_Y_COUNT, yc);
    write_reg(tti_pkg::CFG_D_COUNT, dc);
    write_reg(tti_pkg::CFG_ROW_MAJOR, {4'd0, rm});
  endtask

  // monotone breakpoint vector; a zero gap now and then
  task automatic load_axis(tti_pkg::req_t rq, int n, output int lo, output int hi);
    int v;
    v = $urandom_range(0, 4) == 0 ? -$urandom_range(0, 32'h7fff_0000) : -$urandom_range(0, 32'h80000);
    lo = v;
    for (int i = 0; i < n; i++) begin
      send_item(rq, 11'(i), v, $urandom, $urandom, $urandom);
      hi = v;
      if ($urandom_range(0, 7) != 0) v += $urandom_range(1, 32'h40000);
    end
  endtask

  // values rise with the in-plane offset and the layer
  task automatic load_table();
    int v;
    for (int i = 0; i < 2048; i++) begin
      v = (i / 256) * 32'h80000 + (i % 256) * 32'h8000 + $urandom_range(0, 32'h7fff) - 32'h400000;
      send_item(tti_pkg::REQ_WR_TABLE, 11'(i), v, $urandom, $urandom, $urandom);
    end
    t_lo = -32'h400000;
    t_hi = 7 * 32'h80000 + 256 * 32'h8000 - 32'h400000;
  endtask

  task automatic load_axes();
    load_axis(tti_pkg::REQ_WR_X, 16, x_lo, x_hi);
    load_axis(tti_pkg::REQ_WR_Y, 16, y_lo, y_hi);
    load_axis(tti_pkg::REQ_WR_D, 8, d_lo, d_hi);
  endtask

  function automatic logic [31:0] pick(int lo, int hi);
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return $urandom;
    if (r < 4) return (r == 2) ? lo : hi;
    if (lo > hi) return lo;
    return lo + $urandom_range(0, hi - lo) + $signed($urandom_range(0, 32'h20000)) - 32'h10000;
  endfunction

  task automatic random_query(tti_pkg::req_t rq);
    logic [31:0] qx, qy, qz;
    qx = (rq == tti_pkg::REQ_INV_X) ? pick(t_lo, t_hi) : pick(x_lo, x_hi);
    qy = (rq == tti_pkg::REQ_INV_Y) ? pick(t_lo, t_hi) : pick(y_lo, y_hi);
    qz = (rq == tti_pkg::REQ_INV_D) ? pick(t_lo, t_hi) : pick(d_lo, d_hi);
    send_item(rq, 11'($urandom), $urandom, qx, qy, qz);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      random_query(tti_pkg::req_t'(tti_pkg::REQ_FWD + $urandom_range(0, 3)));
    end else if (r < 62) begin
      // random table writes, partly far out of the smooth surface
      send_item(tti_pkg::REQ_WR_TABLE, 11'($urandom),
                $urandom_range(0, 3) == 0 ? $urandom : pick(t_lo, t_hi),
                $urandom, $urandom, $urandom);
    end else if (r < 70) begin
      send_item(tti_pkg::req_t'($urandom_range(1, 3)), 11'($urandom), $urandom,
                $urandom, $urandom, $urandom);
    end else if (r < 80) begin
      load_axis(tti_pkg::req_t'($urandom_range(1, 3)), 8, r, r);
    end else begin
      random_query(tti_pkg::req_t'(tti_pkg::REQ_FWD + $urandom_range(0, 3)));
    end
  endtask

  function automatic logic [4:0] rand_count(int maxc, int top);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 5'd0;
    if (r == 1) return 5'(maxc);
    if (r == 2) return 5'(top);
    return 5'($urandom_range(1, 4));
  endfunction

  initial begin
    pred = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = tti_pkg::REQ_WR_TABLE;
    cfg_we = 1'b0;
    cfg_index = tti_pkg::CFG_X_COUNT;
    cfg_data = '0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_table();
    load_axes();

    // directed: reset counts, every operation, clamping at both ends
    random_query(tti_pkg::REQ_FWD);
    send_item(tti_pkg::REQ_FWD, 11'd0, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(tti_pkg::REQ_FWD, 11'h7ff, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff);
    send_item(tti_pkg::REQ_INV_X, 11'd0, 32'd0, t_lo + 32'h10000, y_lo, d_lo);
    send_item(tti_pkg::REQ_INV_Y, 11'd0, 32'd0, x_hi, t_hi - 32'h10000, d_hi);
    send_item(tti_pkg::REQ_INV_D, 11'd0, 32'd0, x_lo, y_hi, t_lo + 32'h40000);
    send_item(tti_pkg::REQ_INV_X, 11'd0, 32'd0, 32'h8000_0000, y_hi, d_lo);
    send_item(tti_pkg::REQ_INV_D, 11'd0, 32'd0, x_hi, y_lo, 32'h7fff_ffff);
    // writes beyond their stores are dropped
    send_item(tti_pkg::REQ_WR_X, 11'h7ff, 32'h7fff_ffff, 0, 0, 0);
    send_item(tti_pkg::REQ_WR_Y, 11'd16, 32'h8000_0000, 0, 0, 0);
    send_item(tti_pkg::REQ_WR_D, 11'd8, 32'h7fff_ffff, 0, 0, 0);
    random_query(tti_pkg::REQ_FWD);
    drain();

    // single breakpoints, column-major
    set_counts(5'd1, 5'd1, 5'd1, 1'b0);
    for (int i = 0; i < 4; i++) random_query(tti_pkg::req_t'(tti_pkg::REQ_FWD + i));
    drain();
    // zero counts act as one
    set_counts(5'd0, 5'd0, 5'd0, 1'b1);
    for (int i = 0; i < 4; i++) random_query(tti_pkg::req_t'(tti_pkg::REQ_FWD + i));
    drain();
    // counts above maximum clamp; zero gaps and saturating extremes
    set_counts(5'd31, 5'd31, 5'd15, 1'b0);
    send_item(tti_pkg::REQ_WR_X, 11'd1, x_lo, 0, 0, 0);
    send_item(tti_pkg::REQ_WR_TABLE, 11'd1, 32'h7fff_ffff, 0, 0, 0);
    send_item(tti_pkg::REQ_WR_TABLE, 11'd16, 32'h8000_0000, 0, 0, 0);
    send_item(tti_pkg::REQ_FWD, 11'd0, 32'd0, x_lo, 32'h8000_0000, 32'h8000_0000);
    send_item(tti_pkg::REQ_FWD, 11'd0, 32'd0, x_lo + 32'h100, y_lo + 32'h100, d_lo);
    random_query(tti_pkg::REQ_INV_D);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_counts(rand_count(16, 31), rand_count(16, 31), rand_count(8, 15), $urandom_range(0, 1));
      for (int i = 0; i < 10; i++) random_item();
      drain();
    end

    $display("writes: %0d, forward queries: %0d, inverse x/y/depth: %0d/%0d/%0d",
             pred.write_count, pred.query_count[0], pred.query_count[1],
             pred.query_count[2], pred.query_count[3]);
    $display("results checked: %0d over 10 count/layout settings", pred.results_seen);
    if (pred.errors == 0 && pred.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
